[hdl/sdbbr_pkg.sv]
// Shared types, constants and decode helpers for the sense-driven bad block remapper.
// Used by the controller, the table cells, the top level and the port checker.
`timescale 1ns / 1ps

package sdbbr_pkg;

   // Number of (bad, spare) pairs in the remap table, one per cell.
   localparam int TABLE_ENTRIES = 61;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Reset value of the spare ceiling register.
   localparam logic [31:0] SPARE_CEILING_RESET = 32'd136;

   // Register map of the configuration port.
   localparam int          ADDR_W             = 3;
   localparam logic [ADDR_W-1:0] ADDR_SPARE_CEILING = 3'd0;

   // Outcome codes of a result.
   localparam logic [2:0] OUT_NONE        = 3'd0;
   localparam logic [2:0] OUT_MAPPED_NEW  = 3'd1;
   localparam logic [2:0] OUT_ALREADY     = 3'd2;
   localparam logic [2:0] OUT_UNLOCATED   = 3'd3;
   localparam logic [2:0] OUT_REPORTED    = 3'd4;
   localparam logic [2:0] OUT_TABLE_FULL  = 3'd5;
   localparam logic [2:0] OUT_BAD_SENSE   = 3'd6;

   // Sense format and field masks.
   localparam logic [7:0] FMT_MASK       = 8'h7E;
   localparam logic [7:0] FMT_EXTENDED   = 8'h70;
   localparam logic [7:0] EXT_MIN_LEN    = 8'd3;
   localparam logic [7:0] EXT_BLOCK_LEN  = 8'd7;
   localparam logic [7:0] EXT_ASC_LEN    = 8'd13;
   localparam logic [7:0] NONEXT_LEN     = 8'd4;

   // Extended sense keys: no sense, and the two that are mapped out.
   localparam logic [6:0] KEY_NO_SENSE   = 7'h00;
   localparam logic [6:0] KEY_RECOVERED  = 7'h01;
   localparam logic [6:0] KEY_MEDIUM     = 7'h03;

   // Non-extended error codes: no error, and the codes that are mapped out.
   localparam logic [6:0] NX_NO_ERROR    = 7'h00;
   localparam logic [6:0] NX_CODE_01     = 7'h01;
   localparam logic [6:0] NX_CODE_03     = 7'h03;
   localparam logic [6:0] NX_CODE_11     = 7'h11;
   localparam logic [6:0] NX_CODE_12     = 7'h12;
   localparam logic [6:0] NX_CODE_14     = 7'h14;
   localparam logic [6:0] NX_CODE_18     = 7'h18;
   localparam logic [6:0] NX_CODE_19     = 7'h19;

   // Search token that walks down the cell chain.
   typedef struct packed {
      logic [31:0]      key;     // bad block being looked up
      logic [CNT_W-1:0] remain;  // table entries still to compare
      logic             hit;     // block found in an earlier cell
      logic             placed;  // block already written into a free cell
      logic [31:0]      spare;   // new spare, or the stored one on a hit
   } token_type;

   // Controller sequencing.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // True for the non-extended codes that denote a medium defect.
   function automatic logic nonext_mappable(input logic [6:0] code);
      logic hit;
      case (code) inside
         NX_CODE_01, NX_CODE_03, NX_CODE_11, NX_CODE_12,
         NX_CODE_14, NX_CODE_18, NX_CODE_19: hit = 1'b1;
         default:                            hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

[hdl/sdbbr_cell.sv]
// One remap table cell: holds a (bad, spare) pair and passes the search token on.
// Depends on sdbbr_pkg for the token type.
`timescale 1ns / 1ps

module sdbbr_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 prev_valid,
   input  sdbbr_pkg::token_type prev_tok,
   output logic                 next_valid,
   output sdbbr_pkg::token_type next_tok
);

   logic [31:0]          bad_ff;
   logic [31:0]          spare_ff;
   logic                 valid_ff;
   sdbbr_pkg::token_type tok_ff;
   sdbbr_pkg::token_type tok_in;
   logic                 match;
   logic                 place;

   // Compare against the stored entry while the token still covers live entries.
   // The first cell past the live entries takes the block when nothing matched.
   always_comb begin
      match  = prev_valid && (prev_tok.remain != '0) && !prev_tok.hit &&
               (bad_ff == prev_tok.key);
      place  = prev_valid && (prev_tok.remain == '0) && !prev_tok.hit &&
               !prev_tok.placed;
      tok_in = prev_tok;
      if (prev_tok.remain != '0) begin
         tok_in.remain = prev_tok.remain - sdbbr_pkg::CNT_W'(1);
      end
      if (match) begin
         tok_in.hit   = 1'b1;
         tok_in.spare = spare_ff;
      end
      if (place) begin
         tok_in.placed = 1'b1;
      end
   end

   // Token stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   // Table entry storage.
   always_ff @(posedge clock) begin
      if (place) begin
         bad_ff   <= prev_tok.key;
         spare_ff <= prev_tok.spare;
      end
   end

   assign next_valid = valid_ff;
   assign next_tok   = tok_ff;

endmodule

[hdl/sdbbr_ctrl.sv]
// Sense decoder, remap bookkeeping, register port and result register.
// Depends on sdbbr_pkg; drives the head of the cell chain and reads its tail.
`timescale 1ns / 1ps

module sdbbr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_scsi_status,
   input  logic [7:0]                  req_sense_length,
   input  logic [7:0]                  req_sense_byte0,
   input  logic [7:0]                  req_sense_byte1,
   input  logic [7:0]                  req_sense_byte2,
   input  logic [7:0]                  req_sense_byte3,
   input  logic [7:0]                  req_sense_byte4,
   input  logic [7:0]                  req_sense_byte5,
   input  logic [7:0]                  req_sense_byte6,
   input  logic [7:0]                  req_sense_byte12,
   input  logic                        req_driver_error_clear,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_outcome,
   output logic [6:0]                  rsp_sense_key,
   output logic [31:0]                 rsp_error_block,
   output logic [31:0]                 rsp_replacement_block,
   output logic                        rsp_resume_valid,
   output logic [31:0]                 rsp_resume_block,
   output logic [31:0]                 rsp_error_count,
   // Register port.
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sdbbr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   // Cell chain.
   output logic                        head_valid,
   output sdbbr_pkg::token_type        head_tok,
   input  logic                        tail_valid,
   input  sdbbr_pkg::token_type        tail_tok
);

   sdbbr_pkg::state_type          state_ff, state_in;
   logic [31:0]                   spare_ceiling_ff;
   logic [31:0]                   next_spare_ff;
   logic [sdbbr_pkg::CNT_W-1:0]   entry_count_ff;
   logic [31:0]                   bad_total_ff;
   logic                          head_valid_ff;
   sdbbr_pkg::token_type          head_tok_ff;

   // Result held between decode or search and the output register.
   logic [2:0]                    pend_outcome_ff;
   logic [6:0]                    pend_key_ff;
   logic [31:0]                   pend_block_ff;
   logic [31:0]                   pend_repl_ff;
   logic                          pend_resume_ff;
   logic [31:0]                   pend_count_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [2:0]                    rsp_outcome_ff;
   logic [6:0]                    rsp_key_ff;
   logic [31:0]                   rsp_block_ff;
   logic [31:0]                   rsp_repl_ff;
   logic                          rsp_resume_ff;
   logic [31:0]                   rsp_resume_block_ff;
   logic [31:0]                   rsp_count_ff;

   // Decode results.
   logic                          ext_fmt;
   logic                          nonext_fmt;
   logic                          dec_blk_valid;
   logic [31:0]                   dec_block;
   logic [6:0]                    dec_key;
   logic                          dec_mappable;
   logic                          dec_no_error;
   logic                          dec_err_clear;
   logic [2:0]                    dec_outcome;
   logic                          dec_resume;
   logic                          dec_search;
   logic                          dec_bump;
   logic                          table_full;

   logic                          accept;
   logic                          out_load;
   logic                          launch;
   logic                          cfg_write;

   // Register port.
   assign cfg_write = psel && penable && pwrite && (paddr == sdbbr_pkg::ADDR_SPARE_CEILING);
   assign pready    = 1'b1;
   assign prdata    = (paddr == sdbbr_pkg::ADDR_SPARE_CEILING) ? spare_ceiling_ff : '0;

   assign table_full = (entry_count_ff == sdbbr_pkg::CNT_W'(sdbbr_pkg::TABLE_ENTRIES));

   // Sense decode of the offered request.
   always_comb begin
      ext_fmt       = (req_sense_length >= sdbbr_pkg::EXT_MIN_LEN) &&
                      ((req_sense_byte0 & sdbbr_pkg::FMT_MASK) == sdbbr_pkg::FMT_EXTENDED);
      nonext_fmt    = !ext_fmt && (req_sense_length == sdbbr_pkg::NONEXT_LEN);
      dec_blk_valid = 1'b0;
      dec_block     = '0;
      dec_key       = '0;
      dec_mappable  = 1'b0;
      dec_no_error  = 1'b0;
      dec_err_clear = req_driver_error_clear;
      dec_outcome   = sdbbr_pkg::OUT_NONE;
      dec_resume    = 1'b0;
      dec_search    = 1'b0;
      dec_bump      = 1'b0;
      if (req_scsi_status != 8'd0) begin
         if (ext_fmt) begin
            dec_blk_valid = (req_sense_length >= sdbbr_pkg::EXT_BLOCK_LEN) && req_sense_byte0[7];
            dec_block     = {req_sense_byte3, req_sense_byte4, req_sense_byte5, req_sense_byte6};
            dec_key       = {3'b000, req_sense_byte2[3:0]};
            dec_mappable  = (dec_key == sdbbr_pkg::KEY_MEDIUM) ||
                            (dec_key == sdbbr_pkg::KEY_RECOVERED);
            dec_no_error  = (dec_key == sdbbr_pkg::KEY_NO_SENSE) &&
                            !((req_sense_length >= sdbbr_pkg::EXT_ASC_LEN) &&
                              (req_sense_byte12 != 8'd0));
         end else if (nonext_fmt) begin
            dec_blk_valid = req_sense_byte0[7];
            dec_block     = {11'd0, req_sense_byte1[4:0], req_sense_byte2, req_sense_byte3};
            dec_key       = req_sense_byte0[6:0];
            dec_mappable  = sdbbr_pkg::nonext_mappable(dec_key);
            dec_no_error  = (dec_key == sdbbr_pkg::NX_NO_ERROR);
            if (dec_no_error) begin
               dec_err_clear = 1'b1;
            end
         end else begin
            dec_outcome = sdbbr_pkg::OUT_BAD_SENSE;
         end
         if (ext_fmt || nonext_fmt) begin
            if (dec_mappable) begin
               dec_bump = 1'b1;
               if (!dec_blk_valid) begin
                  dec_outcome = sdbbr_pkg::OUT_UNLOCATED;
               end else if (table_full) begin
                  dec_outcome = sdbbr_pkg::OUT_TABLE_FULL;
               end else begin
                  // Outcome and spare come back from the chain; mapping clears the error.
                  dec_search = 1'b1;
                  dec_resume = 1'b1;
               end
            end else begin
               dec_outcome = dec_no_error ? sdbbr_pkg::OUT_NONE : sdbbr_pkg::OUT_REPORTED;
               dec_resume  = dec_blk_valid && dec_err_clear;
            end
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdbbr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dec_search ? sdbbr_pkg::ST_SEARCH : sdbbr_pkg::ST_FINISH;
            end
         end
         sdbbr_pkg::ST_SEARCH: begin
            if (tail_valid) begin
               state_in = sdbbr_pkg::ST_FINISH;
            end
         end
         sdbbr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = sdbbr_pkg::ST_IDLE;
            end
         end
         default: state_in = sdbbr_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         sdbbr_pkg::ST_IDLE:   req_stall = 1'b0;
         sdbbr_pkg::ST_SEARCH: req_stall = 1'b1;
         sdbbr_pkg::ST_FINISH: out_load  = !rsp_valid_ff || !rsp_stall;
         default:              req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;
   assign launch = accept && dec_search;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdbbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Remap bookkeeping: spare ceiling, next spare, fill count and error count.
   always_ff @(posedge clock) begin
      if (reset) begin
         spare_ceiling_ff <= sdbbr_pkg::SPARE_CEILING_RESET;
         next_spare_ff    <= sdbbr_pkg::SPARE_CEILING_RESET;
         entry_count_ff   <= '0;
         bad_total_ff     <= '0;
      end else begin
         if (cfg_write) begin
            spare_ceiling_ff <= pwdata;
            next_spare_ff    <= pwdata;
         end
         if (accept && dec_bump) begin
            bad_total_ff <= bad_total_ff + 32'd1;
         end
         if (tail_valid && !tail_tok.hit) begin
            next_spare_ff  <= tail_tok.spare;
            entry_count_ff <= entry_count_ff + sdbbr_pkg::CNT_W'(1);
         end
      end
   end

   // Chain head: a token starts the search at the first cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= launch;
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         head_tok_ff.key    <= dec_block;
         head_tok_ff.remain <= entry_count_ff;
         head_tok_ff.hit    <= 1'b0;
         head_tok_ff.placed <= 1'b0;
         head_tok_ff.spare  <= next_spare_ff - 32'd1;
      end
   end

   assign head_valid = head_valid_ff;
   assign head_tok   = head_tok_ff;

   // Pending result: filled at decode, completed when the token leaves the chain.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_outcome_ff <= dec_outcome;
         pend_key_ff     <= dec_key;
         pend_block_ff   <= dec_blk_valid ? dec_block : '0;
         pend_repl_ff    <= '0;
         pend_resume_ff  <= dec_resume;
         pend_count_ff   <= dec_bump ? bad_total_ff + 32'd1 : bad_total_ff;
      end else if (tail_valid) begin
         pend_outcome_ff <= tail_tok.hit ? sdbbr_pkg::OUT_ALREADY : sdbbr_pkg::OUT_MAPPED_NEW;
         pend_repl_ff    <= tail_tok.spare;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_outcome_ff      <= pend_outcome_ff;
         rsp_key_ff          <= pend_key_ff;
         rsp_block_ff        <= pend_block_ff;
         rsp_repl_ff         <= pend_repl_ff;
         rsp_resume_ff       <= pend_resume_ff;
         rsp_resume_block_ff <= pend_resume_ff ? pend_block_ff + 32'd1 : '0;
         rsp_count_ff        <= pend_count_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_outcome           = rsp_outcome_ff;
   assign rsp_sense_key         = rsp_key_ff;
   assign rsp_error_block       = rsp_block_ff;
   assign rsp_replacement_block = rsp_repl_ff;
   assign rsp_resume_valid      = rsp_resume_ff;
   assign rsp_resume_block      = rsp_resume_block_ff;
   assign rsp_error_count       = rsp_count_ff;

endmodule

[hdl/sense_driven_bad_block_remap.sv]
// A request is decoded when it is accepted in idle; without a table lookup it passes the finish state
// into the output register, and a located medium or recovered error first walks the 61-cell table chain.
// One request is in work at a time: a new request is stalled until the result has been loaded;
// the search token passes one cell per cycle.
// Reset (synchronous): counters and handshake clear, spare ceiling and next spare return to 136;
// table cells keep their contents, and only entries below the fill count are ever compared.
`timescale 1ns / 1ps

module sense_driven_bad_block_remap (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_scsi_status,
   input  logic [7:0]                  req_sense_length,
   input  logic [7:0]                  req_sense_byte0,
   input  logic [7:0]                  req_sense_byte1,
   input  logic [7:0]                  req_sense_byte2,
   input  logic [7:0]                  req_sense_byte3,
   input  logic [7:0]                  req_sense_byte4,
   input  logic [7:0]                  req_sense_byte5,
   input  logic [7:0]                  req_sense_byte6,
   input  logic [7:0]                  req_sense_byte12,
   input  logic                        req_driver_error_clear,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_outcome,
   output logic [6:0]                  rsp_sense_key,
   output logic [31:0]                 rsp_error_block,
   output logic [31:0]                 rsp_replacement_block,
   output logic                        rsp_resume_valid,
   output logic [31:0]                 rsp_resume_block,
   output logic [31:0]                 rsp_error_count,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sdbbr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   // Token links: link 0 is the chain head, link TABLE_ENTRIES its tail.
   logic                 link_valid [sdbbr_pkg::TABLE_ENTRIES+1];
   sdbbr_pkg::token_type link_tok   [sdbbr_pkg::TABLE_ENTRIES+1];

   // Decode, bookkeeping and result register.
   sdbbr_ctrl u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_scsi_status        (req_scsi_status),
      .req_sense_length       (req_sense_length),
      .req_sense_byte0        (req_sense_byte0),
      .req_sense_byte1        (req_sense_byte1),
      .req_sense_byte2        (req_sense_byte2),
      .req_sense_byte3        (req_sense_byte3),
      .req_sense_byte4        (req_sense_byte4),
      .req_sense_byte5        (req_sense_byte5),
      .req_sense_byte6        (req_sense_byte6),
      .req_sense_byte12       (req_sense_byte12),
      .req_driver_error_clear (req_driver_error_clear),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_outcome            (rsp_outcome),
      .rsp_sense_key          (rsp_sense_key),
      .rsp_error_block        (rsp_error_block),
      .rsp_replacement_block  (rsp_replacement_block),
      .rsp_resume_valid       (rsp_resume_valid),
      .rsp_resume_block       (rsp_resume_block),
      .rsp_error_count        (rsp_error_count),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready),
      .head_valid             (link_valid[0]),
      .head_tok               (link_tok[0]),
      .tail_valid             (link_valid[sdbbr_pkg::TABLE_ENTRIES]),
      .tail_tok               (link_tok[sdbbr_pkg::TABLE_ENTRIES])
   );

   // Row of table cells, each holding one (bad, spare) pair.
   for (genvar i = 0; i < sdbbr_pkg::TABLE_ENTRIES; i++) begin : g_cell
      sdbbr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (link_valid[i]),
         .prev_tok   (link_tok[i]),
         .next_valid (link_valid[i+1]),
         .next_tok   (link_tok[i+1])
      );
   end

endmodule

[hdl/sdbbr_check.sv]
// Port-level checker for the remapper result channel, bound to the top level.
// Depends on sdbbr_pkg for the outcome codes.
`timescale 1ns / 1ps

module sdbbr_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_outcome,
   input logic [31:0] rsp_error_block,
   input logic        rsp_resume_valid,
   input logic [31:0] rsp_resume_block
);

   // A stalled result stays offered with the same outcome.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome))
      else $error("stalled result changed");

   // A mapped block always resumes right after the error block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == sdbbr_pkg::OUT_MAPPED_NEW ||
                    rsp_outcome == sdbbr_pkg::OUT_ALREADY)
      |-> rsp_resume_valid && (rsp_resume_block == rsp_error_block + 32'd1))
      else $error("mapped request without proper resume block");

   // Unlocated errors, a full table and bad sense never resume.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == sdbbr_pkg::OUT_UNLOCATED ||
                    rsp_outcome == sdbbr_pkg::OUT_TABLE_FULL ||
                    rsp_outcome == sdbbr_pkg::OUT_BAD_SENSE)
      |-> !rsp_resume_valid)
      else $error("resume given for a request that cannot resume");

   // Without resume the resume block reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_resume_valid |-> rsp_resume_block == 32'd0)
      else $error("resume block set without resume");

endmodule

bind sense_driven_bad_block_remap sdbbr_check u_sdbbr_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_outcome      (rsp_outcome),
   .rsp_error_block  (rsp_error_block),
   .rsp_resume_valid (rsp_resume_valid),
   .rsp_resume_block (rsp_resume_block)
);

[tb/sv/tb_top.sv]
// Testbench for sense_driven_bad_block_remap: directed and random sense requests, with each
// result predicted by a scoreboard class and checked in order on the result channel.
// Depends on sdbbr_pkg and the sense_driven_bad_block_remap top level.
`timescale 1ns / 1ps

module tb_top;
   import sdbbr_pkg::*;

   localparam int DRAIN_CYCLES   = 70;    // longest lookup plus margin
   localparam int IDLE_LIMIT     = 2000;  // cycles without any transfer before giving up
   localparam int PHASE_REQUESTS = 200;
   localparam int PHASE_COUNT    = 6;
   localparam int POOL_SIZE      = 36;
   localparam int POOL_SHORT     = 18;    // pool entries that also fit a 21-bit address
   localparam int PRINT_LIMIT    = 100;

   localparam logic [6:0] MEDIA_CODES [7] = '{NX_CODE_01, NX_CODE_03, NX_CODE_11, NX_CODE_12,
                                              NX_CODE_14, NX_CODE_18, NX_CODE_19};

   typedef struct {
      logic [7:0] status;
      logic [7:0] length;
      logic [7:0] s0, s1, s2, s3, s4, s5, s6, s12;
      logic       err_clear;
   } sense_request_t;

   typedef struct {
      logic [2:0]  outcome;
      logic [6:0]  key;
      logic [31:0] error_block;
      logic [31:0] replacement;
      logic        resume;
      logic [31:0] resume_block;
      logic [31:0] error_count;
   } remap_result_t;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_RUNS, FLOW_HEAVY} flow_t;

   // Scoreboard: keeps its own copy of the remap table and the expected results.
   class remap_scoreboard;
      logic [31:0]   ceiling;
      logic [31:0]   next_spare;
      logic [31:0]   bad_total;
      int            fill;
      logic [31:0]   bad_blocks [TABLE_ENTRIES];
      logic [31:0]   spare_blocks [TABLE_ENTRIES];
      remap_result_t awaited [$];
      int            errors;
      int            results;

      function new();
         ceiling    = SPARE_CEILING_RESET;
         next_spare = SPARE_CEILING_RESET;
         bad_total  = '0;
         fill       = 0;
         errors     = 0;
         results    = 0;
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Writing the ceiling also reloads the spare allocator.
      function void set_ceiling(input logic [31:0] value);
         ceiling    = value;
         next_spare = value;
      endfunction

      // Decode one accepted request and queue the result it must produce.
      function void note_request(input sense_request_t r);
         remap_result_t e;
         logic          located, mappable, no_error, decoded, clear, hit;
         logic [6:0]    code;
         logic [31:0]   blk;
         int            j;
         e         = '{default: '0};
         located   = 1'b0;
         mappable  = 1'b0;
         no_error  = 1'b0;
         decoded   = 1'b1;
         hit       = 1'b0;
         clear     = r.err_clear;
         code      = '0;
         blk       = '0;
         if (r.status != 8'd0) begin
            if (r.length >= EXT_MIN_LEN && (r.s0 & FMT_MASK) == FMT_EXTENDED) begin
               // Extended sense: key in byte 2, 32-bit block in bytes 3 to 6.
               if (r.length >= EXT_BLOCK_LEN && r.s0[7]) begin
                  located = 1'b1;
                  blk     = {r.s3, r.s4, r.s5, r.s6};
               end
               code     = {3'b000, r.s2[3:0]};
               mappable = (code == KEY_MEDIUM) || (code == KEY_RECOVERED);
               no_error = (code == KEY_NO_SENSE) && !(r.length >= EXT_ASC_LEN && r.s12 != 8'd0);
            end else if (r.length == NONEXT_LEN) begin
               // Four-byte sense: error code in byte 0, 21-bit block after it.
               if (r.s0[7]) begin
                  located = 1'b1;
                  blk     = {11'd0, r.s1[4:0], r.s2, r.s3};
               end
               code     = r.s0[6:0];
               mappable = 1'b0;
               foreach (MEDIA_CODES[k]) if (code == MEDIA_CODES[k]) mappable = 1'b1;
               no_error = (code == NX_NO_ERROR);
               if (no_error) clear = 1'b1;
            end else begin
               decoded   = 1'b0;
               e.outcome = OUT_BAD_SENSE;
            end

            if (decoded) begin
               if (mappable && located) begin
                  bad_total++;
                  if (fill >= TABLE_ENTRIES) begin
                     e.outcome = OUT_TABLE_FULL;
                  end else begin
                     for (j = 0; j < fill; j++) begin
                        if (!hit && bad_blocks[j] == blk) begin
                           hit           = 1'b1;
                           e.replacement = spare_blocks[j];
                        end
                     end
                     if (hit) begin
                        e.outcome = OUT_ALREADY;
                     end else begin
                        next_spare--;
                        bad_blocks[fill]   = blk;
                        spare_blocks[fill] = next_spare;
                        fill++;
                        e.replacement = next_spare;
                        e.outcome     = OUT_MAPPED_NEW;
                     end
                     clear = 1'b1;
                  end
               end else if (mappable) begin
                  bad_total++;
                  e.outcome = OUT_UNLOCATED;
               end else begin
                  e.outcome = no_error ? OUT_NONE : OUT_REPORTED;
               end
               if (e.outcome != OUT_TABLE_FULL && located && clear) begin
                  e.resume       = 1'b1;
                  e.resume_block = blk + 32'd1;
               end
            end
         end
         e.key         = code;
         e.error_block = located ? blk : 32'd0;
         e.error_count = bad_total;
         awaited.push_back(e);
      endfunction

      // Compare one accepted result with the oldest expectation.
      task check_result(input remap_result_t got);
         remap_result_t want;
         results++;
         if (awaited.size() == 0) begin
            report($sformatf("result %0d arrived with no request pending", results));
            return;
         end
         want = awaited.pop_front();
         if (got.outcome !== want.outcome)
            report($sformatf("result %0d outcome %0d, expected %0d",
                             results, got.outcome, want.outcome));
         if (got.key !== want.key)
            report($sformatf("result %0d sense_key %h, expected %h",
                             results, got.key, want.key));
         if (got.error_block !== want.error_block)
            report($sformatf("result %0d error_block %h, expected %h",
                             results, got.error_block, want.error_block));
         if (got.replacement !== want.replacement)
            report($sformatf("result %0d replacement_block %h, expected %h",
                             results, got.replacement, want.replacement));
         if (got.resume !== want.resume)
            report($sformatf("result %0d resume_valid %b, expected %b",
                             results, got.resume, want.resume));
         if (got.resume_block !== want.resume_block)
            report($sformatf("result %0d resume_block %h, expected %h",
                             results, got.resume_block, want.resume_block));
         if (got.error_count !== want.error_count)
            report($sformatf("result %0d error_count %0d, expected %0d",
                             results, got.error_count, want.error_count));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_scsi_status = '0;
   logic [7:0]          req_sense_length = '0;
   logic [7:0]          req_sense_byte0 = '0;
   logic [7:0]          req_sense_byte1 = '0;
   logic [7:0]          req_sense_byte2 = '0;
   logic [7:0]          req_sense_byte3 = '0;
   logic [7:0]          req_sense_byte4 = '0;
   logic [7:0]          req_sense_byte5 = '0;
   logic [7:0]          req_sense_byte6 = '0;
   logic [7:0]          req_sense_byte12 = '0;
   logic                req_driver_error_clear = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_outcome;
   logic [6:0]          rsp_sense_key;
   logic [31:0]         rsp_error_block;
   logic [31:0]         rsp_replacement_block;
   logic                rsp_resume_valid;
   logic [31:0]         rsp_resume_block;
   logic [31:0]         rsp_error_count;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   remap_scoreboard     sb = new();
   logic [31:0]         pool [POOL_SIZE];
   int                  burst_left = 0;
   flow_t               flow = FLOW_FREE;
   int                  flow_left = 0;
   int                  run_left = 0;
   logic                run_on = 1'b0;
   logic                stall_next;

   sense_driven_bad_block_remap dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_scsi_status        (req_scsi_status),
      .req_sense_length       (req_sense_length),
      .req_sense_byte0        (req_sense_byte0),
      .req_sense_byte1        (req_sense_byte1),
      .req_sense_byte2        (req_sense_byte2),
      .req_sense_byte3        (req_sense_byte3),
      .req_sense_byte4        (req_sense_byte4),
      .req_sense_byte5        (req_sense_byte5),
      .req_sense_byte6        (req_sense_byte6),
      .req_sense_byte12       (req_sense_byte12),
      .req_driver_error_clear (req_driver_error_clear),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_outcome            (rsp_outcome),
      .rsp_sense_key          (rsp_sense_key),
      .rsp_error_block        (rsp_error_block),
      .rsp_replacement_block  (rsp_replacement_block),
      .rsp_resume_valid       (rsp_resume_valid),
      .rsp_resume_block       (rsp_resume_block),
      .rsp_error_count        (rsp_error_count),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Build an extended sense request; unused bits are random.
   function automatic sense_request_t extended_sense(input logic [7:0] length,
         input logic located, input logic [3:0] key, input logic [31:0] blk,
         input logic [7:0] asc, input logic clear);
      sense_request_t r;
      r.status    = 8'($urandom_range(1, 255));
      r.length    = length;
      r.s0        = {located, 7'h70};
      r.s0[0]     = 1'($urandom_range(0, 1));
      r.s1        = 8'($urandom);
      r.s2        = 8'($urandom);
      r.s2[3:0]   = key;
      {r.s3, r.s4, r.s5, r.s6} = blk;
      r.s12       = asc;
      r.err_clear = clear;
      return r;
   endfunction

   // Build a four-byte sense request; unused bits are random.
   function automatic sense_request_t plain_sense(input logic located, input logic [6:0] code,
         input logic [20:0] blk, input logic clear);
      sense_request_t r;
      r.status    = 8'($urandom_range(1, 255));
      r.length    = NONEXT_LEN;
      r.s0        = {located, code};
      r.s1        = 8'($urandom);
      r.s1[4:0]   = blk[20:16];
      r.s2        = blk[15:8];
      r.s3        = blk[7:0];
      {r.s4, r.s5, r.s6, r.s12} = $urandom;
      r.err_clear = clear;
      return r;
   endfunction

   // Mostly well-formed error reports on a pool of blocks, plus noise and broken sense.
   function automatic sense_request_t random_request(input logic fresh);
      sense_request_t r;
      int             roll;
      logic [31:0]    blk;
      logic [3:0]     key;
      logic [6:0]     code;
      logic [7:0]     length;
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
         {r.status, r.length, r.s0, r.s1, r.s2, r.s3} = 48'({$urandom, $urandom});
         {r.s4, r.s5, r.s6, r.s12} = $urandom;
         r.err_clear = 1'($urandom_range(0, 1));
         if (roll >= 8) r.status = 8'd0;
      end else if (roll < 60) begin
         blk    = fresh ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
         length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255)) : 8'd18;
         if ($urandom_range(0, 99) < 65)
            key = $urandom_range(0, 1) ? KEY_MEDIUM[3:0] : KEY_RECOVERED[3:0];
         else
            key = 4'($urandom_range(0, 15));
         r = extended_sense(length, $urandom_range(0, 99) < 85, key, blk,
                            $urandom_range(0, 1) ? 8'h00 : 8'($urandom),
                            1'($urandom_range(0, 1)));
      end else if (roll < 85) begin
         blk  = fresh ? $urandom : pool[$urandom_range(0, POOL_SHORT - 1)];
         code = ($urandom_range(0, 99) < 65) ? MEDIA_CODES[$urandom_range(0, 6)]
                                             : 7'($urandom_range(0, 127));
         r = plain_sense($urandom_range(0, 99) < 85, code, blk[20:0],
                         1'($urandom_range(0, 1)));
      end else begin
         // Broken sense: short extended data or a four-byte format at the wrong length.
         if ($urandom_range(0, 1)) begin
            r = extended_sense(8'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                               KEY_MEDIUM[3:0], $urandom, 8'($urandom),
                               1'($urandom_range(0, 1)));
         end else begin
            r = plain_sense(1'($urandom_range(0, 1)), MEDIA_CODES[$urandom_range(0, 6)],
                            21'($urandom), 1'($urandom_range(0, 1)));
            r.length = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(5, 255));
         end
      end
      return r;
   endfunction

   // Present one request, hold it until accepted, then maybe leave a gap.
   task automatic send_request(input sense_request_t r);
      req_valid              <= 1'b1;
      req_scsi_status        <= r.status;
      req_sense_length       <= r.length;
      req_sense_byte0        <= r.s0;
      req_sense_byte1        <= r.s1;
      req_sense_byte2        <= r.s2;
      req_sense_byte3        <= r.s3;
      req_sense_byte4        <= r.s4;
      req_sense_byte5        <= r.s5;
      req_sense_byte6        <= r.s6;
      req_sense_byte12       <= r.s12;
      req_driver_error_clear <= r.err_clear;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // One access on the register port: setup cycle, then access cycle until ready.
   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= ADDR_SPARE_CEILING;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (write) sb.set_ceiling(wdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait until every expected result is in and the block has gone quiet.
   task automatic settle();
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: check accepted results and stall on a pattern that changes over time.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         sb.check_result('{rsp_outcome, rsp_sense_key, rsp_error_block, rsp_replacement_block,
                           rsp_resume_valid, rsp_resume_block, rsp_error_count});
      if (flow_left == 0) begin
         flow      = flow_t'($urandom_range(0, 3));
         flow_left = $urandom_range(50, 300);
      end else begin
         flow_left--;
      end
      case (flow)
         FLOW_FREE:  stall_next = 1'b0;
         FLOW_LIGHT: stall_next = ($urandom_range(0, 99) < 30);
         FLOW_RUNS: begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 30);
               run_on   = !run_on;
            end else begin
               run_left--;
            end
            stall_next = run_on;
         end
         default:    stall_next = ($urandom_range(0, 99) < 70);
      endcase
      rsp_stall <= stall_next;
   end

   // Give up when nothing moves on any port for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) idle = 0;
         else idle++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence: reset, directed cases, then random phases at several ceilings.
   initial begin : stimulus
      sense_request_t r;
      logic [31:0]    rdata;
      logic [31:0]    ceilings [PHASE_COUNT];
      int             i;
      int             p;

      for (i = 0; i < POOL_SIZE; i++)
         pool[i] = (i < POOL_SHORT) ? 32'($urandom_range(0, 21'h1FFFFF)) : $urandom;
      pool[0]             = 32'h0000_0000;
      pool[1]             = 32'h001F_FFFF;
      pool[POOL_SIZE - 1] = 32'hFFFF_FFFF;
      ceilings = '{SPARE_CEILING_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                   $urandom, 32'h8000_0000};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The ceiling register must come out of reset at its default.
      csr_access(1'b0, 32'd0, rdata);
      if (rdata !== SPARE_CEILING_RESET)
         sb.report($sformatf("spare_ceiling reads %h after reset", rdata));

      // Success status decodes nothing, even with a medium error in the sense bytes.
      r = extended_sense(8'd18, 1'b1, KEY_MEDIUM[3:0], pool[20], 8'h11, 1'b0);
      r.status = 8'h00;
      send_request(r);
      // Extended sense at its shortest: valid bit set but too short for a block.
      send_request(extended_sense(8'd3, 1'b1, KEY_NO_SENSE[3:0], pool[21], 8'h00, 1'b1));
      // Highest block mapped, then found again; resume address wraps to zero.
      send_request(extended_sense(8'd18, 1'b1, KEY_MEDIUM[3:0], pool[POOL_SIZE - 1], 8'h00, 1'b0));
      send_request(extended_sense(8'd255, 1'b1, KEY_MEDIUM[3:0], pool[POOL_SIZE - 1], 8'h00,
                                  1'b0));
      send_request(extended_sense(8'd7, 1'b1, KEY_RECOVERED[3:0], pool[0], 8'h00, 1'b1));
      // Medium error one byte too short to carry its block.
      send_request(extended_sense(8'd6, 1'b1, KEY_MEDIUM[3:0], pool[22], 8'h00, 1'b1));
      // The additional code only counts from thirteen bytes on.
      send_request(extended_sense(8'd12, 1'b0, KEY_NO_SENSE[3:0], pool[23], 8'hFF, 1'b1));
      send_request(extended_sense(8'd13, 1'b0, KEY_NO_SENSE[3:0], pool[23], 8'h01, 1'b1));
      // Other keys are only reported; resume follows the driver error flag.
      send_request(extended_sense(8'd255, 1'b1, 4'hF, pool[24], 8'h00, 1'b1));
      send_request(extended_sense(8'd18, 1'b1, 4'h5, pool[25], 8'h00, 1'b0));
      // Four-byte sense with no error clears the driver error.
      send_request(plain_sense(1'b1, NX_NO_ERROR, pool[2][20:0], 1'b0));
      send_request(plain_sense(1'b0, NX_NO_ERROR, pool[3][20:0], 1'b0));
      // Every mappable four-byte code, the first one at the widest address.
      for (i = 0; i < 7; i++)
         send_request(plain_sense(1'b1, MEDIA_CODES[i], pool[(i == 0) ? 1 : 4 + i][20:0], 1'b0));
      send_request(plain_sense(1'b1, 7'h7F, pool[1][20:0], 1'b1));
      send_request(plain_sense(1'b0, NX_CODE_11, pool[5][20:0], 1'b1));
      // Sense that fits neither format.
      r = plain_sense(1'b1, 7'h05, pool[6][20:0], 1'b1);
      r.length = 8'd5;
      send_request(r);
      send_request(extended_sense(8'd0, 1'b1, KEY_MEDIUM[3:0], pool[7], 8'h00, 1'b1));
      r = extended_sense(8'd2, 1'b1, KEY_MEDIUM[3:0], pool[8], 8'h00, 1'b1);
      r.status = 8'hFF;
      send_request(r);
      // A format byte next to the extended codes is read as a four-byte code.
      send_request(plain_sense(1'b1, 7'h72, pool[9][20:0], 1'b1));
      req_valid <= 1'b0;
      settle();

      // Random phases; the last one uses fresh blocks until the table overflows.
      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p != 0) begin
            csr_access(1'b1, ceilings[p], rdata);
            csr_access(1'b0, 32'd0, rdata);
            if (rdata !== ceilings[p])
               sb.report($sformatf("spare_ceiling reads %h after writing %h", rdata, ceilings[p]));
         end
         for (i = 0; i < PHASE_REQUESTS; i++)
            send_request(random_request(p == PHASE_COUNT - 1));
         req_valid <= 1'b0;
         settle();
      end

      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
